// File: hw/rtl/bmc_pkg.sv
`default_nettype none

package bmc_pkg;

    // Character codes that take part in matching.
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // Bracket kinds as held on the stack.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_BRACE = 2'd1;
    localparam logic [1:0] KIND_SQUARE = 2'd2;
    localparam logic [1:0] KIND_PAREN = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_RUNNING = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_UNCLOSED = 3'd2;
    localparam logic [2:0] ST_BALANCED = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_OTHER,
        OP_OPEN,
        OP_CLOSE
    } op_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       is_last;
    } sym_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] nesting_depth;
        logic [9:0] error_position;
        logic       expression_done;
    } res_word_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] kind;
        logic       is_last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/bmc_front.sv
`default_nettype none

module bmc_front (
    input  wire bmc_pkg::sym_word_t word,
    output bmc_pkg::cmd_t           cmd
);
    import bmc_pkg::*;

    always_comb
    begin
        cmd.is_last = word.is_last;
        unique case (word.symbol)
            CH_LBRACE:
            begin
                cmd.op = OP_OPEN;
                cmd.kind = KIND_BRACE;
            end
            CH_LSQUARE:
            begin
                cmd.op = OP_OPEN;
                cmd.kind = KIND_SQUARE;
            end
            CH_LPAREN:
            begin
                cmd.op = OP_OPEN;
                cmd.kind = KIND_PAREN;
            end
            CH_RBRACE:
            begin
                cmd.op = OP_CLOSE;
                cmd.kind = KIND_BRACE;
            end
            CH_RSQUARE:
            begin
                cmd.op = OP_CLOSE;
                cmd.kind = KIND_SQUARE;
            end
            CH_RPAREN:
            begin
                cmd.op = OP_CLOSE;
                cmd.kind = KIND_PAREN;
            end
            default:
            begin
                cmd.op = OP_OTHER;
                cmd.kind = KIND_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/bmc_queue.sv
`default_nettype none

module bmc_queue (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     wr_en,
    input  wire bmc_pkg::cmd_t      wr_data,
    input  wire                     rd_en,
    output bmc_pkg::cmd_t           rd_data,
    output bmc_pkg::q_status_t      status
);
    import bmc_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = entry_reg[rd_ptr_reg];
    assign status.full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

// File: hw/rtl/bmc_back.sv
`default_nettype none

module bmc_back #(
    parameter int STACK_DEPTH = 64,
    parameter int MAX_CHARS = 1024
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire bmc_pkg::cmd_t      cmd,
    input  wire bmc_pkg::q_status_t q_status,
    output logic                    cmd_take,
    output logic                    res_valid,
    input  wire                     res_stall,
    output bmc_pkg::res_word_t      res_word
);
    import bmc_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(MAX_CHARS);

    // The top of the stack and the entry below it are kept ready, so that
    // a pop can follow a pop in the next cycle. After a pop the entry below
    // comes from the registered memory read; after a push it is the old top.
    logic [1:0]    stack_mem [STACK_DEPTH];
    logic [1:0]    mem_rd_reg;
    logic [1:0]    top_reg;
    logic [1:0]    top_next;
    logic [1:0]    below_reg;
    logic [1:0]    below_next;
    logic          below_sel_reg;
    logic          below_sel_next;
    logic [1:0]    below_val;
    logic [DW-1:0] depth_reg;
    logic [DW-1:0] depth_next;
    logic [DW-1:0] depth_out;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic          err_reg;
    logic          err_next;
    logic          err_chk;
    logic          err_ovf_reg;
    logic          err_ovf_next;
    logic          err_ovf_chk;
    logic [IW-1:0] err_idx_reg;
    logic [IW-1:0] err_idx_next;
    logic [IW-1:0] err_idx_chk;
    logic [2:0]    status;
    logic          do_push;
    logic          do_pop;
    logic [DW-1:0] rd_depth;
    logic          res_valid_reg;
    logic          res_valid_next;
    res_word_t     res_word_reg;

    assign cmd_take = !q_status.empty && (!res_valid_reg || !res_stall);
    assign below_val = below_sel_reg ? mem_rd_reg : below_reg;
    assign rd_depth = depth_reg - DW'(3);

    always_comb
    begin
        do_push = 1'b0;
        do_pop = 1'b0;
        status = ST_RUNNING;
        err_chk = err_reg;
        err_ovf_chk = err_ovf_reg;
        err_idx_chk = err_idx_reg;
        depth_out = depth_reg;
        if (!err_reg)
        begin
            unique case (cmd.op)
                OP_OPEN:
                begin
                    if (depth_reg == DW'(STACK_DEPTH))
                    begin
                        err_chk = 1'b1;
                        err_ovf_chk = 1'b1;
                        err_idx_chk = idx_reg;
                        status = ST_OVERFLOW;
                    end
                    else
                    begin
                        do_push = 1'b1;
                        depth_out = depth_reg + 1'b1;
                    end
                end
                OP_CLOSE:
                begin
                    if (depth_reg == '0 || top_reg != cmd.kind)
                    begin
                        err_chk = 1'b1;
                        err_ovf_chk = 1'b0;
                        err_idx_chk = idx_reg;
                        status = ST_MISMATCH;
                    end
                    else
                    begin
                        do_pop = 1'b1;
                        depth_out = depth_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.is_last)
        begin
            if (err_chk)
            begin
                status = err_ovf_chk ? ST_OVERFLOW : ST_MISMATCH;
            end
            else if (depth_out != '0)
            begin
                status = ST_UNCLOSED;
            end
            else
            begin
                status = ST_BALANCED;
            end
        end
    end

    always_comb
    begin
        top_next = top_reg;
        below_next = below_reg;
        below_sel_next = below_sel_reg;
        depth_next = depth_reg;
        idx_next = idx_reg;
        err_next = err_reg;
        err_ovf_next = err_ovf_reg;
        err_idx_next = err_idx_reg;
        if (cmd_take)
        begin
            if (do_push)
            begin
                top_next = cmd.kind;
                below_next = top_reg;
                below_sel_next = 1'b0;
            end
            else if (do_pop)
            begin
                top_next = below_val;
                below_sel_next = 1'b1;
            end
            if (cmd.is_last)
            begin
                depth_next = '0;
                idx_next = '0;
                err_next = 1'b0;
                err_ovf_next = 1'b0;
                err_idx_next = '0;
            end
            else
            begin
                depth_next = depth_out;
                err_next = err_chk;
                err_ovf_next = err_ovf_chk;
                err_idx_next = err_idx_chk;
                if (idx_reg != IW'(MAX_CHARS - 1))
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd_take)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            idx_reg <= '0;
            err_reg <= 1'b0;
            err_ovf_reg <= 1'b0;
            err_idx_reg <= '0;
            below_sel_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            idx_reg <= idx_next;
            err_reg <= err_next;
            err_ovf_reg <= err_ovf_next;
            err_idx_reg <= err_idx_next;
            below_sel_reg <= below_sel_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        below_reg <= below_next;
        if (cmd_take)
        begin
            res_word_reg.status <= status;
            res_word_reg.nesting_depth <= 7'(depth_out);
            res_word_reg.error_position <= err_chk ? 10'(err_idx_chk) : 10'd0;
            res_word_reg.expression_done <= cmd.is_last;
        end
    end

    // Stack memory: one write port for pushes, one registered read for pops.
    always_ff @(posedge clk)
    begin
        if (cmd_take && do_push)
        begin
            stack_mem[depth_reg[AW-1:0]] <= cmd.kind;
        end
        if (cmd_take && do_pop)
        begin
            mem_rd_reg <= stack_mem[rd_depth[AW-1:0]];
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word = res_word_reg;

endmodule

`default_nettype wire

// File: hw/rtl/bracket_match_checker_top.sv
`default_nettype none

// Balanced bracket checker for braces, square brackets and parentheses. One
// character word is accepted per cycle unless sym_stall is high, and each
// gives exactly one registered result word. The front classifies each
// character, a two-word queue decouples it from the back, and the back keeps
// the bracket stack: the top entry and the one below it are held in registers
// beside the stack memory, so any mix of pushes and pops runs at one word per
// cycle while res_stall is low. The first mismatch or overflow is reported with
// its position and freezes checking until the last character, whose result
// gives the final verdict and clears the state for the next expression.
module bracket_match_checker_top #(
    parameter int STACK_DEPTH = 64,
    parameter int MAX_CHARS = 1024
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     sym_valid,
    output logic                    sym_stall,
    input  wire bmc_pkg::sym_word_t sym_word,
    output logic                    res_valid,
    input  wire                     res_stall,
    output bmc_pkg::res_word_t      res_word
);
    import bmc_pkg::*;

    cmd_t      front_cmd;
    cmd_t      head_cmd;
    q_status_t q_status;
    logic      cmd_take;
    logic      sym_accept;

    assign sym_stall = q_status.full;
    assign sym_accept = sym_valid && !q_status.full;

    bmc_front u_front (
        .word (sym_word),
        .cmd  (front_cmd)
    );

    bmc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (sym_accept),
        .wr_data (front_cmd),
        .rd_en   (cmd_take),
        .rd_data (head_cmd),
        .status  (q_status)
    );

    bmc_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_CHARS   (MAX_CHARS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .q_status  (q_status),
        .cmd_take  (cmd_take),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule

`default_nettype wire
